### rtl/resonator_bank_windowed_rms_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef RESONATOR_BANK_WINDOWED_RMS_MACROS_SVH
`define RESONATOR_BANK_WINDOWED_RMS_MACROS_SVH
`ifndef SYNTHESIS
`define RBWR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbwr assertion failed");
`define RBWR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbwr assertion failed");
`else
`define RBWR_ASSERT_SAME(label, clk, rst, ante, cons)
`define RBWR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/rbwr_pkg.sv
package rbwr_pkg;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] sample_value;
    logic        [3:0]  band_index;
    logic signed [31:0] band_a1_coef;
  } in_word_t;

  typedef struct packed {
    logic               kind;
    logic        [3:0]  band;
    logic signed [31:0] value;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] y1;
    logic signed [31:0] y2;
    logic signed [31:0] a1;
    logic        [63:0] sum;
  } band_rec_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_SQ,
    ST_ACC,
    ST_RMS_START,
    ST_RMS_WAIT,
    ST_RMS_EMIT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    RT_IDLE,
    RT_DIV,
    RT_ROOT,
    RT_DONE
  } root_state_t;

  localparam logic [1:0] REG_A2     = 2'd0;
  localparam logic [1:0] REG_B1     = 2'd1;
  localparam logic [1:0] REG_WINDOW = 2'd2;
  localparam logic [1:0] REG_EMIT   = 2'd3;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_LOAD   = 1'b1;

  localparam logic KIND_RESP = 1'b0;
  localparam logic KIND_RMS  = 1'b1;

  localparam logic signed [31:0] RMS_MAX = 32'sh7fff_ffff;

endpackage

### rtl/rbwr_cell.sv
module rbwr_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  logic                load_coef,
  input  logic signed [31:0]  coef,
  input  rbwr_pkg::band_rec_t rec_in,
  output rbwr_pkg::band_rec_t rec
);
  import rbwr_pkg::*;

  // Filter state clears at reset; the coefficient is undefined until loaded.
  always_ff @(posedge clk) begin
    if (shift) begin
      rec.a1 <= rec_in.a1;
    end else if (load_coef) begin
      rec.a1 <= coef;
    end
    if (rst) begin
      rec.y1  <= '0;
      rec.y2  <= '0;
      rec.sum <= '0;
    end else if (shift) begin
      rec.y1  <= rec_in.y1;
      rec.y2  <= rec_in.y2;
      rec.sum <= rec_in.sum;
    end
  end

endmodule

### rtl/rbwr_root_unit.sv
module rbwr_root_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [63:0]        dividend,
  input  logic [15:0]        divisor,
  output logic               done,
  output logic signed [31:0] result
);
  import rbwr_pkg::*;

  root_state_t state, state_next;
  logic [63:0] quo;
  logic [16:0] drem;
  logic [34:0] rrem;
  logic [31:0] root;
  logic [15:0] dvs;
  logic [5:0]  cnt;
  logic [16:0] dshift;
  logic [34:0] rshift;
  logic [34:0] rtest;

  assign dshift = {drem[15:0], quo[63]};
  assign rshift = {rrem[32:0], quo[63:62]};
  assign rtest  = {1'b0, root, 2'b01};

  always_comb begin
    state_next = state;
    case (state)
      RT_IDLE: if (start) state_next = RT_DIV;
      RT_DIV:  if (cnt == 6'd63) state_next = RT_ROOT;
      RT_ROOT: if (cnt == 6'd31) state_next = RT_DONE;
      RT_DONE: state_next = RT_IDLE;
      default: state_next = RT_IDLE;
    endcase
  end

  always_comb begin
    done   = (state == RT_DONE);
    result = (root > 32'h7fff_ffff) ? RMS_MAX : $signed(root);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RT_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == RT_DIV || state == RT_ROOT) begin
        cnt <= (state_next == state) ? cnt + 6'd1 : 6'd0;
      end else begin
        cnt <= '0;
      end
    end
  end

  // Restoring divide, one quotient bit a cycle, then a two-bit-a-cycle root.
  always_ff @(posedge clk) begin
    case (state)
      RT_IDLE: begin
        if (start) begin
          quo  <= dividend;
          dvs  <= divisor;
          drem <= '0;
          rrem <= '0;
          root <= '0;
        end
      end
      RT_DIV: begin
        if (dshift >= {1'b0, dvs}) begin
          drem <= dshift - {1'b0, dvs};
          quo  <= {quo[62:0], 1'b1};
        end else begin
          drem <= dshift;
          quo  <= {quo[62:0], 1'b0};
        end
      end
      RT_ROOT: begin
        quo <= {quo[61:0], 2'b00};
        if (rshift >= rtest) begin
          rrem <= rshift - rtest;
          root <= {root[30:0], 1'b1};
        end else begin
          rrem <= rshift;
          root <= {root[30:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/resonator_bank_windowed_rms.sv
// Each sample runs through every band in turn: multiply, sum, square, accumulate.
//   A coefficient load is written straight into its band cell from idle.
// At a window end each band also passes through the shared divide/root unit.
// Throughput: one word at a time; the next is taken when the ring is back at rest.
// Reset (rst, synchronous): clears filters, sums, window count; presets registers.
`include "resonator_bank_windowed_rms_macros.svh"
module resonator_bank_windowed_rms #(
  parameter int NUM_BANDS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  rbwr_pkg::in_word_t  sample_word,
  output logic                result_valid,
  input  logic                result_stall,
  output rbwr_pkg::out_word_t result_word,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [31:0]         wr_data
);
  import rbwr_pkg::*;

  localparam int BW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam logic [BW-1:0] LAST_BAND = BW'(NUM_BANDS - 1);

  // Configuration registers.
  logic signed [31:0] a2_coef;
  logic signed [31:0] b1_coef;
  logic [15:0]        window_length;
  logic               emit_response;

  always_ff @(posedge clk) begin
    if (rst) begin
      a2_coef       <= '0;
      b1_coef       <= 32'sh4000_0000;
      window_length <= 16'd1024;
      emit_response <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_A2:     a2_coef       <= wr_data;
        REG_B1:     b1_coef       <= wr_data;
        REG_WINDOW: window_length <= wr_data[15:0];
        REG_EMIT:   emit_response <= wr_data[0];
        default: begin
        end
      endcase
    end
  end

  ctrl_state_t state, state_next;

  logic accept;
  logic sample_go;
  logic load_go;
  logic out_free;
  logic out_load;
  out_word_t out_next;
  logic ring_shift;
  logic band_last;
  logic acc_go;

  logic [BW-1:0]      band_cnt;
  logic [15:0]        window_count;
  logic               wend;
  logic [15:0]        win;
  logic [15:0]        count_inc;

  logic signed [47:0] t1;
  logic signed [63:0] p1;
  logic signed [63:0] p2;
  logic signed [31:0] y;
  logic signed [63:0] sq;

  logic signed [65:0] acc;
  logic signed [37:0] y_wide;
  logic signed [31:0] y_sat;
  logic [64:0]        sum_wide;
  logic [63:0]        sum_sat;

  band_rec_t ring [NUM_BANDS];
  band_rec_t head;
  band_rec_t head_upd;

  logic               root_start;
  logic               root_done;
  logic signed [31:0] root_value;

  assign head      = ring[0];
  assign accept    = sample_valid && !sample_stall;
  assign sample_go = accept && (sample_word.mode == MODE_SAMPLE);
  assign load_go   = accept && (sample_word.mode == MODE_LOAD);
  assign out_free  = !result_valid || !result_stall;
  assign band_last = (band_cnt == LAST_BAND);
  assign win       = (window_length == 16'd0) ? 16'd1 : window_length;
  assign count_inc = window_count + 16'd1;

  // Filter arithmetic: b1*s scaled by 32, feedback terms floored by 4,
  // round half up to Q9.22 and saturate.
  always_comb begin
    acc = (66'(t1) <<< 5) - 66'(p1 >>> 2) - 66'(p2 >>> 2) + 66'sd134217728;
    y_wide = acc[65:28];
    if (y_wide > 38'sh0_7fff_ffff) begin
      y_sat = 32'sh7fff_ffff;
    end else if (y_wide < -38'sh0_8000_0000) begin
      y_sat = -32'sh8000_0000;
    end else begin
      y_sat = y_wide[31:0];
    end
    sum_wide = {1'b0, head.sum} + {1'b0, sq};
    sum_sat  = sum_wide[64] ? '1 : sum_wide[63:0];
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (sample_go) state_next = ST_MUL;
      ST_MUL:       state_next = ST_SUM;
      ST_SUM:       state_next = ST_SQ;
      ST_SQ:        state_next = ST_ACC;
      ST_ACC: begin
        if (acc_go) begin
          if (!band_last) state_next = ST_MUL;
          else if (wend)  state_next = ST_RMS_START;
          else            state_next = ST_IDLE;
        end
      end
      ST_RMS_START: state_next = ST_RMS_WAIT;
      ST_RMS_WAIT:  if (root_done) state_next = ST_RMS_EMIT;
      ST_RMS_EMIT: begin
        if (out_free) state_next = band_last ? ST_IDLE : ST_RMS_START;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    sample_stall = (state != ST_IDLE);
    acc_go       = (state == ST_ACC) && (!emit_response || out_free);
    root_start   = (state == ST_RMS_START);
    out_load     = 1'b0;
    ring_shift   = 1'b0;
    head_upd     = head;
    out_next     = '0;
    out_next.band = 4'(band_cnt);
    case (state)
      ST_ACC: begin
        head_upd.y2  = head.y1;
        head_upd.y1  = y;
        head_upd.sum = sum_sat;
        ring_shift   = acc_go;
        out_load     = acc_go && emit_response;
        out_next.kind  = KIND_RESP;
        out_next.value = y;
        out_next.last  = band_last && !wend;
      end
      ST_RMS_EMIT: begin
        head_upd.sum = '0;
        ring_shift   = out_free;
        out_load     = out_free;
        out_next.kind  = KIND_RMS;
        out_next.value = root_value;
        out_next.last  = band_last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      band_cnt     <= '0;
      window_count <= '0;
      wend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (sample_go) begin
        band_cnt     <= '0;
        wend         <= (count_inc >= win);
        window_count <= (count_inc >= win) ? 16'd0 : count_inc;
      end else if (ring_shift) begin
        // Wrap the band counter when the ring is back in place.
        band_cnt <= band_last ? '0 : band_cnt + 1'b1;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath registers: t1, p1, p2 and sq hold products; y the saturated sum.
  always_ff @(posedge clk) begin
    if (sample_go) t1 <= b1_coef * sample_word.sample_value;
    if (state == ST_MUL) begin
      p1 <= head.a1 * head.y1;
      p2 <= a2_coef * head.y2;
    end
    if (state == ST_SUM) y <= y_sat;
    if (state == ST_SQ) sq <= y * y;
    if (out_load) result_word <= out_next;
  end

  // Ring of band cells: cell 0 is the head seen by the shared arithmetic.
  for (genvar i = 0; i < NUM_BANDS; i++) begin : g_cell
    band_rec_t nb;
    if (i == NUM_BANDS - 1) begin : g_tail
      assign nb = head_upd;
    end else begin : g_mid
      assign nb = ring[i+1];
    end
    rbwr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (ring_shift),
      .load_coef (load_go && ({1'b0, sample_word.band_index} == 5'(i))),
      .coef      (sample_word.band_a1_coef),
      .rec_in    (nb),
      .rec       (ring[i])
    );
  end

  rbwr_root_unit u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .dividend (head.sum),
    .divisor  (win),
    .done     (root_done),
    .result   (root_value)
  );

  `RBWR_ASSERT_NEXT(a_sample_starts, clk, rst, sample_go, state == ST_MUL)
  `RBWR_ASSERT_SAME(a_root_done_wait, clk, rst, root_done, state == ST_RMS_WAIT)
  `RBWR_ASSERT_SAME(a_shift_busy, clk, rst, ring_shift, state != ST_IDLE)
  `RBWR_ASSERT_NEXT(a_idle_after_last, clk, rst,
                    (state == ST_RMS_EMIT) && out_free && band_last, state == ST_IDLE)

endmodule

### tb/tb_resonator_bank_windowed_rms.sv
module tb_resonator_bank_windowed_rms;
  import rbwr_pkg::*;

  localparam int NB = 16;
  // Settle time before a register write: one sample ring plus every band in the root unit.
  localparam int SETTLE = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        sample_valid = 1'b0;
  logic        sample_stall;
  in_word_t    sample_word = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  out_word_t   result_word;
  logic        wr_en = 1'b0;
  logic [1:0]  wr_index = REG_A2;
  logic [31:0] wr_data = '0;

  resonator_bank_windowed_rms #(.NUM_BANDS(NB)) u_top (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample_word(sample_word),
    .result_valid(result_valid), .result_stall(result_stall), .result_word(result_word),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Filter bank mirror: register copies and per-band state.
  logic signed [31:0] a2_coef;
  logic signed [31:0] gain_b1;
  logic [15:0]        win_len;
  logic               emit_on;
  logic signed [31:0] y1_q [NB];
  logic signed [31:0] y2_q [NB];
  logic signed [31:0] a1_tab [NB];
  logic [63:0]        energy [NB];
  logic [15:0]        win_count;
  logic signed [31:0] last_resp [NB];

  out_word_t pending_results[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int words_sent = 0;
  int results_seen = 0;
  int rms_seen = 0;

  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bitv;
    r = '0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // Advance the bank by one word and queue the words it must produce.
  task automatic run_bank(in_word_t w);
    logic signed [63:0] t1, t2, t3, acc;
    logic [63:0]        sq, r;
    logic [64:0]        tot;
    logic [15:0]        win;
    out_word_t          batch[$];
    out_word_t          o;
    if (w.mode == MODE_LOAD) begin
      a1_tab[w.band_index] = w.band_a1_coef;
      return;
    end
    for (int b = 0; b < NB; b++) begin
      t1 = gain_b1;
      t1 = t1 * w.sample_value * 64'sd32;
      t2 = a1_tab[b];
      t2 = (t2 * y1_q[b]) >>> 2;
      t3 = a2_coef;
      t3 = (t3 * y2_q[b]) >>> 2;
      acc = (t1 - t2 - t3 + 64'sd134217728) >>> 28;
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      sq = acc * acc;
      tot = {1'b0, energy[b]} + {1'b0, sq};
      energy[b] = tot[64] ? '1 : tot[63:0];
      y2_q[b] = y1_q[b];
      y1_q[b] = acc[31:0];
      last_resp[b] = acc[31:0];
      if (emit_on) begin
        o.kind = KIND_RESP; o.band = b[3:0]; o.value = acc[31:0]; o.last = 1'b0;
        batch.push_back(o);
      end
    end
    win = (win_len == 0) ? 16'd1 : win_len;
    win_count = win_count + 16'd1;
    if (win_count >= win) begin
      win_count = '0;
      for (int b = 0; b < NB; b++) begin
        r = int_root(energy[b] / win);
        if (r > 64'h7fff_ffff) r = 64'h7fff_ffff;
        energy[b] = '0;
        o.kind = KIND_RMS; o.band = b[3:0]; o.value = r[31:0]; o.last = 1'b0;
        batch.push_back(o);
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) pending_results.push_back(batch[i]);
  endtask

  // Result side: check every accepted word, then pick the next stall.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (result_word.kind == KIND_RMS) rms_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", result_word);
      end else begin
        want = pending_results.pop_front();
        if (result_word !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected kind %0d band %0d value %0d last %0d, got kind %0d band %0d value %0d last %0d",
                     want.kind, want.band, want.value, want.last, result_word.kind,
                     result_word.band, result_word.value, result_word.last);
        end
      end
    end
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Hand one word to the block; return on the edge that accepts it.
  task automatic send_word(in_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    sample_valid <= 1'b1;
    sample_word <= w;
    do @(posedge clk); while (sample_stall);
    words_sent++;
    run_bank(w);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    case (idx)
      REG_A2:     a2_coef = data;
      REG_B1:     gain_b1 = data;
      REG_WINDOW: win_len = data[15:0];
      REG_EMIT:   emit_on = data[0];
      default: begin
      end
    endcase
  endtask

  // Drain everything outstanding, then let a silent word finish.
  task automatic wait_idle();
    sample_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic in_word_t random_word();
    in_word_t w;
    w = in_word_t'(($bits(in_word_t))'({$urandom, $urandom}));
    if ($urandom_range(5) == 0) begin
      w.mode = MODE_LOAD;
      case ($urandom_range(5))
        0: w.band_a1_coef = 32'sh8000_0000;
        1: w.band_a1_coef = 32'sh7fff_ffff;
        2: w.band_a1_coef = $urandom_range(32'h4000_0000, 32'h7fff_0000);
        default: w.band_a1_coef = $urandom;
      endcase
    end else begin
      w.mode = MODE_SAMPLE;
      case ($urandom_range(7))
        0: w.sample_value = 16'sh7fff;
        1: w.sample_value = 16'sh8000;
        2: w.sample_value = 16'($urandom_range(63)) - 16'd32;
        default: w.sample_value = 16'($urandom);
      endcase
    end
    return w;
  endfunction

  typedef struct {
    logic               mode;
    logic signed [15:0] smp;
    logic [3:0]         band;
    logic signed [31:0] a1;
    bit                 chk;
    logic signed [31:0] resp;
  } dir_row_t;

  typedef struct {
    logic [31:0] a2;
    logic [31:0] b1;
    logic [15:0] win;
    logic        emit;
    int          items;
  } phase_t;

  dir_row_t rows[$];
  phase_t   phases[6];

  initial begin
    in_word_t w;
    a2_coef = '0; gain_b1 = 32'sh4000_0000; win_len = 16'd1024; emit_on = 1'b0;
    win_count = '0;
    for (int b = 0; b < NB; b++) begin
      y1_q[b] = '0; y2_q[b] = '0; a1_tab[b] = '0; energy[b] = '0; last_resp[b] = '0;
    end

    // Load every band first so no unwritten coefficient is ever read.
    for (int b = 0; b < NB; b++) rows.push_back('{MODE_LOAD, 0, 4'(b), 0, 0, 0});
    // With a1 = a2 = 0 and unit gain the response is just the sample times 128.
    rows.push_back('{MODE_SAMPLE, 16'sh7fff, 0, 0, 1, 32'sd4194176});
    rows.push_back('{MODE_SAMPLE, 16'sh8000, 0, 0, 1, -32'sd4194304});
    rows.push_back('{MODE_SAMPLE, 16'sh0000, 0, 0, 1, 32'sd0});
    rows.push_back('{MODE_LOAD, 0, 4'd3, 32'sh8000_0000, 0, 0});
    rows.push_back('{MODE_LOAD, 0, 4'd15, 32'sh7fff_ffff, 0, 0});
    rows.push_back('{MODE_SAMPLE, 16'sh7fff, 0, 0, 0, 0});
    rows.push_back('{MODE_SAMPLE, -16'sd1, 0, 0, 0, 0});
    rows.push_back('{MODE_SAMPLE, 16'sd1, 0, 0, 0, 0});

    phases[0] = '{32'h1234_5678, 32'h2000_0000, 16'd1, 1'b0, 60};
    phases[1] = '{32'h8000_0000, 32'h7fff_ffff, 16'd0, 1'b1, 50};
    phases[2] = '{32'h7fff_ffff, 32'h8000_0000, 16'd7, 1'b1, 80};
    phases[3] = '{32'hc000_0000, 32'h3fff_ffff, 16'd65535, 1'b0, 20};
    // Lower the window while a long one is still open.
    phases[4] = '{32'h3a00_0000, 32'h0800_0000, 16'd5, 1'b1, 100};
    phases[5] = '{32'hf000_0001, 32'h4000_0000, 16'd3, 1'b0, 100};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 37; recv_stall_pct = 76;
    write_reg(REG_EMIT, 32'd1);
    write_reg(REG_WINDOW, 32'd4);
    wr_en <= 1'b0;
    foreach (rows[i]) begin
      w = in_word_t'(($bits(in_word_t))'({$urandom, $urandom}));
      w.mode = rows[i].mode;
      if (rows[i].mode == MODE_LOAD) begin
        w.band_index = rows[i].band;
        w.band_a1_coef = rows[i].a1;
      end else begin
        w.sample_value = rows[i].smp;
      end
      send_word(w);
      if (rows[i].chk)
        for (int b = 0; b < NB; b++)
          if (last_resp[b] !== rows[i].resp) begin
            mismatches++;
            if (mismatches <= 10)
              $display("directed row %0d band %0d: expected %0d, computed %0d",
                       i, b, rows[i].resp, last_resp[b]);
          end
    end

    foreach (phases[p]) begin
      wait_idle();
      case (p / 2)
        0: begin send_idle_pct = 37; recv_stall_pct = 76; end
        1: begin send_idle_pct = 76; recv_stall_pct = 37; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      write_reg(REG_A2, phases[p].a2);
      write_reg(REG_B1, phases[p].b1);
      write_reg(REG_WINDOW, {16'd0, phases[p].win});
      write_reg(REG_EMIT, {31'd0, phases[p].emit});
      wr_en <= 1'b0;
      repeat (phases[p].items) send_word(random_word());
    end

    wait_idle();
    if (pending_results.size() > 0) mismatches++;
    $display("sent %0d words through %0d register settings; checked %0d results, %0d of them RMS",
             words_sent, 7, results_seen, rms_seen);
    if (mismatches == 0) $display("resonator_bank_windowed_rms verification clean");
    else $display("resonator_bank_windowed_rms verification failed");
    $finish;
  end

  initial begin
    #60000000;
    $display("resonator_bank_windowed_rms verification failed");
    $finish;
  end

endmodule

### resonator_bank_windowed_rms.f
+incdir+rtl
rtl/rbwr_pkg.sv
rtl/rbwr_cell.sv
rtl/rbwr_root_unit.sv
rtl/resonator_bank_windowed_rms.sv
tb/tb_resonator_bank_windowed_rms.sv
